// File: rtl/core/bounding_box_normalize_points_defines.svh
`ifndef BOUNDING_BOX_NORMALIZE_POINTS_DEFINES_SVH
`define BOUNDING_BOX_NORMALIZE_POINTS_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define BBN_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define BBN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/bbn_pkg.sv
package bbn_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // operation codes
  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_APPLY   = 1'b1;

  typedef logic [1:0] axis_t;

  localparam axis_t AXIS_X = 2'd0;
  localparam axis_t AXIS_Y = 2'd1;
  localparam axis_t AXIS_Z = 2'd2;
  localparam axis_t AXIS_END = 2'd3;

  // sequencer to bounds store
  typedef struct packed {
    logic  upd;
    logic  seed;
    logic  widen;
    axis_t axis;
  } box_ctl_t;

  // divider status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
    logic sat;
  } div_sts_t;

endpackage

// File: rtl/core/bbn_box.sv
module bbn_box #(
  parameter int COORD_WIDTH = bbn_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bbn_pkg::box_ctl_t             ctl,
  input  logic signed [COORD_WIDTH-1:0] coord,
  output logic        [COORD_WIDTH-1:0] extent
);
  import bbn_pkg::*;

  logic signed [COORD_WIDTH-1:0] min_r [3];
  logic signed [COORD_WIDTH-1:0] max_r [3];
  logic signed [COORD_WIDTH-1:0] sel_min;
  logic signed [COORD_WIDTH-1:0] sel_max;
  logic signed [COORD_WIDTH:0]   diff;
  logic        [COORD_WIDTH:0]   diff_abs;
  logic        [COORD_WIDTH-1:0] extent_r;

  // per-axis seed and widen, one axis per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        min_r[k] <= '0;
        max_r[k] <= '0;
      end
    end else if (ctl.upd) begin
      for (int k = 0; k < 3; k++) begin
        if (ctl.axis == axis_t'(k)) begin
          if (ctl.seed) begin
            min_r[k] <= coord;
            max_r[k] <= coord;
          end else if (ctl.widen) begin
            if (coord < min_r[k]) begin
              min_r[k] <= coord;
            end
            if (coord > max_r[k]) begin
              max_r[k] <= coord;
            end
          end
        end
      end
    end
  end

  always_comb begin
    case (ctl.axis)
      AXIS_Y: begin
        sel_min = min_r[1];
        sel_max = max_r[1];
      end
      AXIS_Z: begin
        sel_min = min_r[2];
        sel_max = max_r[2];
      end
      default: begin
        sel_min = min_r[0];
        sel_max = max_r[0];
      end
    endcase
  end

  assign diff     = {sel_max[COORD_WIDTH-1], sel_max} - {sel_min[COORD_WIDTH-1], sel_min};
  assign diff_abs = diff[COORD_WIDTH] ? (~diff + 1'b1) : diff;

  always_ff @(posedge clk) begin
    extent_r <= diff_abs[COORD_WIDTH-1:0];
  end

  assign extent = extent_r;

endmodule

// File: rtl/core/bbn_div.sv
module bbn_div #(
  parameter int COORD_WIDTH = bbn_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = bbn_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [COORD_WIDTH-1:0] coord,
  input  logic        [COORD_WIDTH-1:0] scale,
  output logic signed [COORD_WIDTH-1:0] quot,
  output bbn_pkg::div_sts_t             sts
);
  import bbn_pkg::*;

  localparam int QW   = COORD_WIDTH + FRAC_BITS;
  localparam int CNTW = $clog2(QW + 1);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

  localparam logic [QW-1:0] LIM_POS = {{(FRAC_BITS+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [QW-1:0] LIM_NEG = {{FRAC_BITS{1'b0}}, 1'b1, {(COORD_WIDTH-1){1'b0}}};

  dstate_t                  state_r;
  logic [CNTW-1:0]          cnt_r;
  logic                     neg_r;
  logic [COORD_WIDTH-1:0]   div_r;
  logic [COORD_WIDTH-1:0]   rem_r;
  logic [QW-1:0]            dvd_r;
  logic [QW-1:0]            quo_r;
  logic signed [COORD_WIDTH-1:0] quot_r;
  logic                     done_r;
  logic                     sat_r;

  logic [COORD_WIDTH-1:0]   mag;
  logic [COORD_WIDTH:0]     trial;
  logic                     qbit;
  logic [COORD_WIDTH-1:0]   rem_nxt;
  logic [QW-1:0]            lim;
  logic                     over;
  logic [COORD_WIDTH-1:0]   q_sel;

  assign mag     = coord[COORD_WIDTH-1] ? (~coord + 1'b1) : coord;
  // one restoring step a cycle
  assign trial   = {rem_r, dvd_r[QW-1]};
  assign qbit    = (trial >= {1'b0, div_r});
  assign rem_nxt = qbit ? COORD_WIDTH'(trial - {1'b0, div_r}) : trial[COORD_WIDTH-1:0];

  assign lim   = neg_r ? LIM_NEG : LIM_POS;
  assign over  = (quo_r > lim);
  assign q_sel = over ? lim[COORD_WIDTH-1:0] : quo_r[COORD_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        D_IDLE: begin
          if (start) begin
            neg_r   <= coord[COORD_WIDTH-1];
            div_r   <= scale;
            rem_r   <= '0;
            dvd_r   <= {mag, {FRAC_BITS{1'b0}}};
            quo_r   <= '0;
            cnt_r   <= CNTW'(QW);
            state_r <= D_RUN;
          end
        end
        D_RUN: begin
          rem_r <= rem_nxt;
          dvd_r <= {dvd_r[QW-2:0], 1'b0};
          quo_r <= {quo_r[QW-2:0], qbit};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CNTW'(1)) begin
            state_r <= D_FIN;
          end
        end
        D_FIN: begin
          // clip to range, then restore sign
          quot_r  <= neg_r ? (~q_sel + 1'b1) : q_sel;
          sat_r   <= over;
          done_r  <= 1'b1;
          state_r <= D_IDLE;
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  assign quot     = quot_r;
  assign sts.busy = (state_r != D_IDLE);
  assign sts.done = done_r;
  assign sts.sat  = sat_r;

endmodule

// File: rtl/core/bounding_box_normalize_points.sv
// channel  | direction | handshake             | payload
// in_      | input     | in_valid / in_ready   | operation, first_point, active, x/y/z_coord
// out_     | output    | out_valid / out_ready | x/y/z_out, zero_scale, saturated
//
// measure point: the bounds unit updates the X, Y and Z axes in turn, then ready returns
// apply point, active: each coordinate is divided by the largest axis extent, using the
//   shared radix-2 divider that runs one quotient bit per cycle for each axis in turn
// apply point, inactive or zero scale: no divide
// reset: synchronous, active low; bounds clear to zero, no result pending
// a stalled result sits in the output register; the next point is taken meanwhile

`include "bounding_box_normalize_points_defines.svh"

module bounding_box_normalize_points #(
  parameter int COORD_WIDTH = bbn_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = bbn_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_operation,
  input  logic                          in_first_point,
  input  logic                          in_active,
  input  logic signed [COORD_WIDTH-1:0] in_x_coord,
  input  logic signed [COORD_WIDTH-1:0] in_y_coord,
  input  logic signed [COORD_WIDTH-1:0] in_z_coord,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_x_out,
  output logic signed [COORD_WIDTH-1:0] out_y_out,
  output logic signed [COORD_WIDTH-1:0] out_z_out,
  output logic                          out_zero_scale,
  output logic                          out_saturated
);
  import bbn_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MEAS, S_SCALE, S_DSTART, S_DWAIT, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  axis_t  axis_r, axis_nxt;
  logic   first_r, first_nxt;
  logic   act_r, act_nxt;

  // captured point
  logic signed [COORD_WIDTH-1:0] cx_r, cx_nxt, cy_r, cy_nxt, cz_r, cz_nxt;
  // running largest extent
  logic [COORD_WIDTH-1:0] scale_r, scale_nxt;
  // working result
  logic signed [COORD_WIDTH-1:0] rx_r, rx_nxt, ry_r, ry_nxt, rz_r, rz_nxt;
  logic zero_r, zero_nxt, sat_r, sat_nxt;
  // output register
  logic out_valid_r, out_valid_nxt;
  logic signed [COORD_WIDTH-1:0] ox_r, ox_nxt, oy_r, oy_nxt, oz_r, oz_nxt;
  logic ozero_r, ozero_nxt, osat_r, osat_nxt;

  logic                          accept;
  logic signed [COORD_WIDTH-1:0] cur_coord;
  box_ctl_t                      box_ctl;
  logic [COORD_WIDTH-1:0]        extent;
  logic                          div_start;
  logic signed [COORD_WIDTH-1:0] div_quot;
  div_sts_t                      div_sts;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // coordinate of the axis being worked on
  always_comb begin
    case (axis_r)
      AXIS_Y:  cur_coord = cy_r;
      AXIS_Z:  cur_coord = cz_r;
      default: cur_coord = cx_r;
    endcase
  end

  assign box_ctl.upd   = (state_r == S_MEAS);
  assign box_ctl.seed  = first_r;
  assign box_ctl.widen = act_r;
  assign box_ctl.axis  = axis_r;

  bbn_box #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_box (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (box_ctl),
    .coord (cur_coord),
    .extent(extent)
  );

  assign div_start = (state_r == S_DSTART) && (scale_r != '0);

  bbn_div #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .coord(cur_coord),
    .scale(scale_r),
    .quot (div_quot),
    .sts  (div_sts)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    first_nxt     = first_r;
    act_nxt       = act_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    cz_nxt        = cz_r;
    scale_nxt     = scale_r;
    rx_nxt        = rx_r;
    ry_nxt        = ry_r;
    rz_nxt        = rz_r;
    zero_nxt      = zero_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r;
    ox_nxt        = ox_r;
    oy_nxt        = oy_r;
    oz_nxt        = oz_r;
    ozero_nxt     = ozero_r;
    osat_nxt      = osat_r;

    // result taken downstream
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          first_nxt = in_first_point;
          act_nxt   = in_active;
          cx_nxt    = in_x_coord;
          cy_nxt    = in_y_coord;
          cz_nxt    = in_z_coord;
          // pass-through values unless a divide overwrites them
          rx_nxt    = in_x_coord;
          ry_nxt    = in_y_coord;
          rz_nxt    = in_z_coord;
          zero_nxt  = 1'b0;
          sat_nxt   = 1'b0;
          scale_nxt = '0;
          axis_nxt  = AXIS_X;
          if (in_operation == OP_MEASURE) begin
            state_nxt = S_MEAS;
          end else if (in_active) begin
            state_nxt = S_SCALE;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_MEAS: begin
        // bounds unit updates one axis per cycle, no result
        if (axis_r == AXIS_Z) begin
          state_nxt = S_IDLE;
        end else begin
          axis_nxt = axis_r + 1'b1;
        end
      end
      S_SCALE: begin
        // extent is registered in the bounds unit, so it belongs to the previous axis
        if (axis_r != AXIS_X) begin
          if (extent > scale_r) begin
            scale_nxt = extent;
          end
        end
        if (axis_r == AXIS_END) begin
          axis_nxt  = AXIS_X;
          state_nxt = S_DSTART;
        end else begin
          axis_nxt = axis_r + 1'b1;
        end
      end
      S_DSTART: begin
        if (scale_r == '0) begin
          zero_nxt  = 1'b1;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_DWAIT;
        end
      end
      S_DWAIT: begin
        if (div_sts.done) begin
          case (axis_r)
            AXIS_Y:  ry_nxt = div_quot;
            AXIS_Z:  rz_nxt = div_quot;
            default: rx_nxt = div_quot;
          endcase
          sat_nxt = sat_r | div_sts.sat;
          if (axis_r == AXIS_Z) begin
            state_nxt = S_OUT;
          end else begin
            axis_nxt  = axis_r + 1'b1;
            state_nxt = S_DSTART;
          end
        end
      end
      S_OUT: begin
        // load once the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          ox_nxt        = rx_r;
          oy_nxt        = ry_r;
          oz_nxt        = rz_r;
          ozero_nxt     = zero_r;
          osat_nxt      = sat_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= AXIS_X;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      out_valid_r <= out_valid_nxt;
    end
    first_r <= first_nxt;
    act_r   <= act_nxt;
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    cz_r    <= cz_nxt;
    scale_r <= scale_nxt;
    rx_r    <= rx_nxt;
    ry_r    <= ry_nxt;
    rz_r    <= rz_nxt;
    zero_r  <= zero_nxt;
    sat_r   <= sat_nxt;
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
    oz_r    <= oz_nxt;
    ozero_r <= ozero_nxt;
    osat_r  <= osat_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_x_out      = ox_r;
  assign out_y_out      = oy_r;
  assign out_z_out      = oz_r;
  assign out_zero_scale = ozero_r;
  assign out_saturated  = osat_r;

  // a zero-scale point never divides, so it cannot saturate
  `BBN_ASSERT_NOW(a_flags_excl, clk, rst_n, out_valid,
                  !(out_zero_scale && out_saturated), "zero_scale and saturated both set")
  // one point at a time: busy right after a transaction
  `BBN_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready,
                   !in_ready, "ready held after accept")
  // a quotient only lands while the sequencer waits for it
  `BBN_ASSERT_NOW(a_div_done_wait, clk, rst_n, div_sts.done,
                  state_r == S_DWAIT, "divider result outside wait state")
  // the divider is only started while idle
  `BBN_ASSERT_NOW(a_div_start_idle, clk, rst_n, div_start,
                  !div_sts.busy, "divider started while busy")

endmodule
